// ===== rtl/core/cfd_pkg.sv =====
// Shared types, constants and the CRC-16/XMODEM byte update for the deframer.
// No dependencies; imported by every module of the block.
package cfd_pkg;

    localparam int LEN_W = 11;
    localparam int OFF_W = 10;
    localparam int CRC_W = 16;

    localparam logic [LEN_W-1:0] PAYLOAD_LIMIT = 11'd1024;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 11'd1024;
    localparam logic [LEN_W-1:0] REC_BYTES_RESET = 11'd76;

    localparam logic [7:0] SYNC_A = 8'h5A;
    localparam logic [7:0] SYNC_B = 8'hA5;
    localparam logic [7:0] TAG_BYTE = 8'h91;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REC_BYTES = 1'b1;

    typedef struct packed {
        logic [7:0]       payload_byte;
        logic [OFF_W-1:0] byte_offset;
        logic             data_valid;
        logic             last;
        logic [LEN_W-1:0] payload_length;
        logic             crc_ok;
        logic             record_found;
        logic [OFF_W-1:0] record_offset;
    } cfd_result_t;

    // One byte through CRC-16/XMODEM, MSB first, unrolled over 8 bit steps.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/cfd_parser.sv =====
// Frame parser: sync hunt, length/CRC header, payload tracking, record tag search.
// Depends on cfd_pkg. Produces at most one result per accepted byte.
module cfd_parser
    import cfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           rx_byte,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data,
    output logic                 res_valid,
    output cfd_result_t          res
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SYNC_B,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_CRC_LO,
        PH_CRC_HI,
        PH_PAYLOAD
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [7:0]       len_lo_reg, len_lo_next;
    logic [LEN_W-1:0] frame_len_reg, frame_len_next;
    logic [CRC_W-1:0] rx_crc_reg, rx_crc_next;
    logic [CRC_W-1:0] run_crc_reg, run_crc_next;
    logic [LEN_W-1:0] pay_cnt_reg, pay_cnt_next;
    logic [OFF_W-1:0] tag_off_reg, tag_off_next;
    logic             tag_seen_reg, tag_seen_next;
    logic [LEN_W-1:0] max_len_reg;
    logic [LEN_W-1:0] rec_bytes_reg;

    logic [LEN_W-1:0] lim;
    logic [15:0]      len_word;
    logic [LEN_W:0]   fit_sum;
    logic             tag_fits;
    logic [CRC_W-1:0] crc_upd;
    logic [CRC_W-1:0] crc_sync_a;

    assign lim        = (max_len_reg > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : max_len_reg;
    assign len_word   = {rx_byte, len_lo_reg};
    assign fit_sum    = {2'b00, pay_cnt_reg[OFF_W-1:0]} + {1'b0, rec_bytes_reg};
    assign tag_fits   = fit_sum <= {1'b0, frame_len_reg};
    assign crc_upd    = crc_byte(run_crc_reg, rx_byte);
    assign crc_sync_a = crc_byte('0, SYNC_A);

    always_comb
    begin
        phase_next     = phase_reg;
        len_lo_next    = len_lo_reg;
        frame_len_next = frame_len_reg;
        rx_crc_next    = rx_crc_reg;
        run_crc_next   = run_crc_reg;
        pay_cnt_next   = pay_cnt_reg;
        tag_off_next   = tag_off_reg;
        tag_seen_next  = tag_seen_reg;
        res_valid      = 1'b0;
        res            = '0;

        case (phase_reg)
            PH_SYNC_B:
            begin
                if (rx_byte == SYNC_B)
                begin
                    run_crc_next = crc_upd;
                    phase_next   = PH_LEN_LO;
                end
                else if (rx_byte == SYNC_A)
                begin
                    run_crc_next = crc_sync_a;
                    phase_next   = PH_SYNC_B;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_LEN_LO:
            begin
                len_lo_next  = rx_byte;
                run_crc_next = crc_upd;
                phase_next   = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                if (len_word > {5'b0, lim})
                begin
                    // abort: rescan the two length bytes as sync
                    if (len_lo_reg == SYNC_A && rx_byte == SYNC_B)
                    begin
                        run_crc_next = crc_byte(crc_sync_a, SYNC_B);
                        phase_next   = PH_LEN_LO;
                    end
                    else if (rx_byte == SYNC_A)
                    begin
                        run_crc_next = crc_sync_a;
                        phase_next   = PH_SYNC_B;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                else
                begin
                    frame_len_next = len_word[LEN_W-1:0];
                    run_crc_next   = crc_upd;
                    phase_next     = PH_CRC_LO;
                end
            end
            PH_CRC_LO:
            begin
                rx_crc_next = {8'h00, rx_byte};
                phase_next  = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                rx_crc_next   = {rx_byte, rx_crc_reg[7:0]};
                pay_cnt_next  = '0;
                tag_seen_next = 1'b0;
                tag_off_next  = '0;
                if (frame_len_reg == '0)
                begin
                    // empty frame end marker
                    res_valid          = 1'b1;
                    res.last           = 1'b1;
                    res.payload_length = frame_len_reg;
                    res.crc_ok         = (run_crc_reg == {rx_byte, rx_crc_reg[7:0]});
                    phase_next         = PH_HUNT;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                run_crc_next = crc_upd;
                if (!tag_seen_reg && rx_byte == TAG_BYTE && tag_fits)
                begin
                    tag_seen_next = 1'b1;
                    tag_off_next  = pay_cnt_reg[OFF_W-1:0];
                end
                pay_cnt_next       = pay_cnt_reg + 1'b1;
                res_valid          = 1'b1;
                res.payload_byte   = rx_byte;
                res.byte_offset    = pay_cnt_reg[OFF_W-1:0];
                res.data_valid     = 1'b1;
                res.payload_length = frame_len_reg;
                if (pay_cnt_next >= frame_len_reg)
                begin
                    res.last          = 1'b1;
                    res.crc_ok        = (crc_upd == rx_crc_reg);
                    res.record_found  = tag_seen_next;
                    res.record_offset = tag_seen_next ? tag_off_next : '0;
                    phase_next        = PH_HUNT;
                end
            end
            default:
            begin
                // hunting, and any stray phase code
                if (rx_byte == SYNC_A)
                begin
                    run_crc_next = crc_sync_a;
                    phase_next   = PH_SYNC_B;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            len_lo_reg    <= '0;
            frame_len_reg <= '0;
            rx_crc_reg    <= '0;
            run_crc_reg   <= '0;
            pay_cnt_reg   <= '0;
            tag_off_reg   <= '0;
            tag_seen_reg  <= 1'b0;
            max_len_reg   <= MAX_LEN_RESET;
            rec_bytes_reg <= REC_BYTES_RESET;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                len_lo_reg    <= len_lo_next;
                frame_len_reg <= frame_len_next;
                rx_crc_reg    <= rx_crc_next;
                run_crc_reg   <= run_crc_next;
                pay_cnt_reg   <= pay_cnt_next;
                tag_off_reg   <= tag_off_next;
                tag_seen_reg  <= tag_seen_next;
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_MAX_LEN:   max_len_reg   <= cfg_data;
                    CFG_REC_BYTES: rec_bytes_reg <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

`ifndef ASSERT_OFF
    a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.data_valid) |-> (res.last && !res.record_found))
        else $error("end marker without last");

    a_count_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (pay_cnt_reg < frame_len_reg))
        else $error("payload count ran past frame length");

    a_last_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.data_valid && res.last)
        |-> ({1'b0, res.byte_offset} + 1'b1 == res.payload_length))
        else $error("last payload byte at wrong offset");

    a_tag_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_PAYLOAD && !tag_seen_reg) |=>
        (!tag_seen_reg || tag_off_reg == $past(pay_cnt_reg[OFF_W-1:0])))
        else $error("record tag offset not taken from current byte");
`endif

endmodule

// ===== rtl/core/cfd_out_reg.sv =====
// Result register between the parser and the output channel.
// Depends on cfd_pkg. Takes a new byte whenever the held result leaves or is empty.
module cfd_out_reg
    import cfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        res_valid,
    input  cfd_result_t res,
    output logic        out_valid,
    input  logic        out_ready,
    output cfd_result_t res_q
);

    logic        valid_reg, valid_next;
    cfd_result_t data_reg;
    logic        load;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign res_q     = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = res_valid;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
            data_reg <= res;
    end

endmodule

// ===== rtl/core/crc_checked_frame_deframer_core.sv =====
// Sync/length/CRC-16 deframer for a serial byte stream.
// Channels: rx_byte beats in on in_valid/in_ready; one result beat per payload
//   byte (or one end marker for an empty frame) out on out_valid/out_ready.
// Frame: 0x5A 0xA5, length (LE 16), CRC-16/XMODEM (LE 16), payload.
//   The CRC covers sync, length and payload. The last beat of a frame carries
//   crc_ok and the offset of the first 0x91 record tag that fits a full record.
//   A length above max_payload_len (capped at 1024) aborts the frame and the
//   length bytes are rescanned as sync.
// Output: each result is registered and appears in the cycle after the byte that causes it.
// Throughput: one byte per cycle while in_ready is high; the next parser state and
//   the CRC byte update (eight unrolled bit steps) are combinational.
// Stall: the result register holds its beat while out_ready is low; in_ready
//   stays high as long as the held beat is leaving or the register is empty.
// Reset: hunting for sync, output empty, max_payload_len 1024, record_bytes 76.
// Config: cfg_write_en with cfg_index (0 max_payload_len, 1 record_bytes)
//   writes cfg_data; write only while no frame is in flight.
module crc_checked_frame_deframer_core
    import cfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // byte input
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           rx_byte,
    // result output
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           payload_byte,
    output logic [OFF_W-1:0]     byte_offset,
    output logic                 data_valid,
    output logic                 last,
    output logic [LEN_W-1:0]     payload_length,
    output logic                 crc_ok,
    output logic                 record_found,
    output logic [OFF_W-1:0]     record_offset,
    // configuration
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data
);

    logic        accept;
    logic        res_valid;
    cfd_result_t res;
    cfd_result_t res_q;

    // byte is consumed by the parser exactly when the input beat completes
    assign accept = in_valid && in_ready;

    cfd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .rx_byte      (rx_byte),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .res_valid    (res_valid),
        .res          (res)
    );

    cfd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .res_valid (res_valid),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_q     (res_q)
    );

    assign payload_byte   = res_q.payload_byte;
    assign byte_offset    = res_q.byte_offset;
    assign data_valid     = res_q.data_valid;
    assign last           = res_q.last;
    assign payload_length = res_q.payload_length;
    assign crc_ok         = res_q.crc_ok;
    assign record_found   = res_q.record_found;
    assign record_offset  = res_q.record_offset;

endmodule

// ===== sim/cfd_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the sync/length/CRC-16 deframer, plus a small CRC helper package.
// Depends on cfd_pkg (result struct, sync/tag constants, register indexes).

package cfd_tb_pkg;

    import cfd_pkg::*;

    // CRC-16/XMODEM, one input bit at a time, MSB first.
    function automatic logic [15:0] xmodem_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        int          i;
        c = crc;
        for (i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

endpackage

module cfd_result_checker
    import cfd_pkg::*;
    import cfd_tb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [7:0]           rx_byte,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [7:0]           payload_byte,
    input  logic [OFF_W-1:0]     byte_offset,
    input  logic                 data_valid,
    input  logic                 last,
    input  logic [LEN_W-1:0]     payload_length,
    input  logic                 crc_ok,
    input  logic                 record_found,
    input  logic [OFF_W-1:0]     record_offset,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data,
    output int                   mismatches,
    output int                   pending,
    output logic                 hunting
);

    typedef enum logic [2:0] {
        P_HUNT,
        P_SYNC_B,
        P_LEN_LO,
        P_LEN_HI,
        P_CRC_LO,
        P_CRC_HI,
        P_PAYLOAD
    } parse_phase_t;

    parse_phase_t     phase;
    logic [7:0]       len_lo;
    logic [LEN_W-1:0] frame_len;
    logic [15:0]      rx_crc;
    logic [15:0]      run_crc;
    logic [LEN_W-1:0] count;
    logic [OFF_W-1:0] tag_off;
    logic             tag_hit;
    logic [LEN_W-1:0] max_len;
    logic [LEN_W-1:0] rec_len;

    cfd_result_t beats_due[$];

    assign hunting = (phase == P_HUNT);

    function automatic string beat_str(input cfd_result_t r);
        return $sformatf("byte=%h off=%0d dv=%b last=%b len=%0d ok=%b rec=%b roff=%0d",
                         r.payload_byte, r.byte_offset, r.data_valid, r.last,
                         r.payload_length, r.crc_ok, r.record_found, r.record_offset);
    endfunction

    task automatic start_hunt(input logic [7:0] b);
        if (b == SYNC_A)
        begin
            phase   = P_SYNC_B;
            run_crc = xmodem_next(16'h0000, SYNC_A);
        end
        else
        begin
            phase = P_HUNT;
        end
    endtask

    // Advance the parser by one accepted byte; queue the beat it causes, if any.
    task automatic deframe_byte(input logic [7:0] b);
        cfd_result_t beat;
        logic [15:0] decl_len;
        int          cap;
        beat = '0;
        case (phase)
            P_SYNC_B:
            begin
                if (b == SYNC_B)
                begin
                    run_crc = xmodem_next(run_crc, b);
                    phase   = P_LEN_LO;
                end
                else
                begin
                    start_hunt(b);
                end
            end
            P_LEN_LO:
            begin
                len_lo  = b;
                run_crc = xmodem_next(run_crc, b);
                phase   = P_LEN_HI;
            end
            P_LEN_HI:
            begin
                decl_len = {b, len_lo};
                cap = (max_len > PAYLOAD_LIMIT) ? int'(PAYLOAD_LIMIT) : int'(max_len);
                if (int'(decl_len) > cap)
                begin
                    // length bytes get a second look as sync
                    if (len_lo == SYNC_A && b == SYNC_B)
                    begin
                        run_crc = xmodem_next(xmodem_next(16'h0000, SYNC_A), SYNC_B);
                        phase   = P_LEN_LO;
                    end
                    else
                    begin
                        start_hunt(b);
                    end
                end
                else
                begin
                    frame_len = decl_len[LEN_W-1:0];
                    run_crc   = xmodem_next(run_crc, b);
                    phase     = P_CRC_LO;
                end
            end
            P_CRC_LO:
            begin
                rx_crc = {8'h00, b};
                phase  = P_CRC_HI;
            end
            P_CRC_HI:
            begin
                rx_crc[15:8] = b;
                count        = '0;
                tag_hit      = 1'b0;
                tag_off      = '0;
                if (frame_len == '0)
                begin
                    beat.last           = 1'b1;
                    beat.payload_length = frame_len;
                    beat.crc_ok         = (run_crc == rx_crc);
                    beats_due.push_back(beat);
                    phase = P_HUNT;
                end
                else
                begin
                    phase = P_PAYLOAD;
                end
            end
            P_PAYLOAD:
            begin
                run_crc = xmodem_next(run_crc, b);
                if (!tag_hit && b == TAG_BYTE && int'(count) + int'(rec_len) <= int'(frame_len))
                begin
                    tag_hit = 1'b1;
                    tag_off = count[OFF_W-1:0];
                end
                beat.payload_byte   = b;
                beat.byte_offset    = count[OFF_W-1:0];
                beat.data_valid     = 1'b1;
                beat.payload_length = frame_len;
                count = count + 1'b1;
                if (count >= frame_len)
                begin
                    beat.last          = 1'b1;
                    beat.crc_ok        = (run_crc == rx_crc);
                    beat.record_found  = tag_hit;
                    beat.record_offset = tag_hit ? tag_off : '0;
                    phase = P_HUNT;
                end
                beats_due.push_back(beat);
            end
            default:
            begin
                start_hunt(b);
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        cfd_result_t got;
        cfd_result_t want;
        logic        bad;
        if (!rst_n)
        begin
            phase     = P_HUNT;
            len_lo    = '0;
            frame_len = '0;
            rx_crc    = '0;
            run_crc   = '0;
            count     = '0;
            tag_off   = '0;
            tag_hit   = 1'b0;
            max_len   = MAX_LEN_RESET;
            rec_len   = REC_BYTES_RESET;
            beats_due.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {payload_byte, byte_offset, data_valid, last, payload_length,
                       crc_ok, record_found, record_offset};
                if (beats_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected beat %s", $time, beat_str(got));
                    mismatches++;
                end
                else
                begin
                    want = beats_due.pop_front();
                    bad = (got.payload_byte   !== want.payload_byte)   ||
                          (got.byte_offset    !== want.byte_offset)    ||
                          (got.data_valid     !== want.data_valid)     ||
                          (got.last           !== want.last)           ||
                          (got.payload_length !== want.payload_length) ||
                          (got.crc_ok         !== want.crc_ok)         ||
                          (got.record_found   !== want.record_found)   ||
                          (got.record_offset  !== want.record_offset);
                    if (bad)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: beat mismatch", $time);
                            $display("    exp %s", beat_str(want));
                            $display("    got %s", beat_str(got));
                        end
                        mismatches++;
                    end
                end
            end
            if (cfg_write_en)
            begin
                if (cfg_index == CFG_MAX_LEN)
                    max_len = cfg_data;
                else if (cfg_index == CFG_REC_BYTES)
                    rec_len = cfg_data;
            end
            if (in_valid && in_ready)
                deframe_byte(rx_byte);
            pending = beats_due.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the deframer testbench: clock, reset, byte stimulus, register writes, verdict.
// Depends on cfd_pkg, cfd_tb_pkg and cfd_result_checker (sim/cfd_result_checker.sv).
module tb_top
    import cfd_pkg::*;
    import cfd_tb_pkg::*;
;

    // Slowest run is about a thousand bytes; this cycle limit is far above it.
    localparam int RUN_LIMIT = 1000000;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [7:0]           rx_byte = 8'h00;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [7:0]           payload_byte;
    logic [OFF_W-1:0]     byte_offset;
    logic                 data_valid;
    logic                 last;
    logic [LEN_W-1:0]     payload_length;
    logic                 crc_ok;
    logic                 record_found;
    logic [OFF_W-1:0]     record_offset;
    logic                 cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_MAX_LEN;
    logic [LEN_W-1:0]     cfg_data = '0;

    int          mismatches;
    int          pending;
    logic        hunting;
    int unsigned cycle_count = 0;
    int          sent_bytes = 0;
    bit          in_quiet = 1'b0;
    bit          out_quiet = 1'b0;
    int          frame_cap = 1024;  // effective length limit, tracks the last register write

    crc_checked_frame_deframer_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .payload_byte   (payload_byte),
        .byte_offset    (byte_offset),
        .data_valid     (data_valid),
        .last           (last),
        .payload_length (payload_length),
        .crc_ok         (crc_ok),
        .record_found   (record_found),
        .record_offset  (record_offset),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Watches both channels and the register port, predicts and compares.
    cfd_result_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .payload_byte   (payload_byte),
        .byte_offset    (byte_offset),
        .data_valid     (data_valid),
        .last           (last),
        .payload_length (payload_length),
        .crc_ok         (crc_ok),
        .record_found   (record_found),
        .record_offset  (record_offset),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .pending        (pending),
        .hunting        (hunting)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Reset once, released on a rising edge.
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog: a hung handshake or a lost beat ends up here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: a fresh random stall before every beat, with quiet
    // stretches where out_ready simply stays high.
    initial
    begin : result_sink
        int stall;
        int beats;
        beats = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (beats % 40 == 0)
                out_quiet = ($urandom_range(0, 3) == 0);
            stall = out_quiet ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            beats++;
        end
    end

    // One input beat. valid is only dropped when a gap is drawn, so back-to-back
    // beats keep it high without a low/high pair in the same step.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (sent_bytes % 50 == 0)
            in_quiet = ($urandom_range(0, 3) == 0);
        gap = in_quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_bytes++;
    endtask

    // Drop in_valid and wait for every predicted beat to leave.
    // pending is read on the falling edge to stay clear of the checker's update.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // Bring the parser back to hunting before touching registers. Zero bytes
    // never start a frame, so padding past the end is harmless.
    task automatic settle();
        drain();
        while (!hunting)
        begin
            repeat (16) push_byte(8'h00);
            drain();
        end
    endtask

    // Both registers, back to back; only called with the parser idle.
    task automatic set_limits(input logic [LEN_W-1:0] max_len, input logic [LEN_W-1:0] rec);
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_MAX_LEN;
        cfg_data     <= max_len;
        @(posedge clk);
        cfg_index    <= CFG_REC_BYTES;
        cfg_data     <= rec;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        frame_cap = (max_len > PAYLOAD_LIMIT) ? int'(PAYLOAD_LIMIT) : int'(max_len);
    endtask

    // Mostly short payloads; a few medium ones.
    function automatic int pick_len();
        int hi;
        hi = ($urandom_range(0, 4) == 0) ? 64 : 20;
        if (hi > frame_cap)
            hi = frame_cap;
        return $urandom_range(0, hi);
    endfunction

    // Whole frame. tag_at < 0: random body with tags sprinkled in; otherwise the
    // only tag sits at tag_at. skip drops leading header bytes, for frames whose
    // sync the parser already holds after a rescan.
    task automatic send_frame(input int len, input bit good_crc, input int tag_at,
                              input int skip);
        logic [7:0]  body[$];
        logic [7:0]  hdr[4];
        logic [15:0] len16;
        logic [15:0] crc;
        logic [7:0]  v;
        int          k;
        len16 = len[15:0];
        hdr = '{SYNC_A, SYNC_B, len16[7:0], len16[15:8]};
        crc = 16'h0000;
        for (k = 0; k < 4; k++)
            crc = xmodem_next(crc, hdr[k]);
        for (k = 0; k < len; k++)
        begin
            if (tag_at < 0)
            begin
                v = ($urandom_range(0, 5) == 0) ? TAG_BYTE : 8'($urandom_range(0, 255));
            end
            else
            begin
                v = 8'($urandom_range(0, 255));
                if (v == TAG_BYTE)
                    v = ~v;
                if (k == tag_at)
                    v = TAG_BYTE;
            end
            body.push_back(v);
            crc = xmodem_next(crc, v);
        end
        if (!good_crc)
            crc = crc ^ 16'($urandom_range(1, 65535));
        for (k = skip; k < 4; k++)
            push_byte(hdr[k]);
        push_byte(crc[7:0]);
        push_byte(crc[15:8]);
        foreach (body[k])
            push_byte(body[k]);
    endtask

    task automatic send_bad_length(input logic [15:0] len16);
        push_byte(SYNC_A);
        push_byte(SYNC_B);
        push_byte(len16[7:0]);
        push_byte(len16[15:8]);
    endtask

    // Broken sequences: 0 sync pair broken, 1 length over the limit,
    // 2 oversize length that reads as a full sync, 3 oversize length whose high
    // byte reads as a first sync byte. 2 and 3 are followed by the frame they open.
    task automatic send_broken(input int kind);
        logic [7:0] v;
        case (kind)
            0:
            begin
                v = 8'($urandom_range(0, 255));
                if (v == SYNC_B)
                    v = SYNC_A;
                push_byte(SYNC_A);
                push_byte(v);
            end
            1:
            begin
                send_bad_length(16'($urandom_range(frame_cap + 1, 65535)));
            end
            2:
            begin
                send_bad_length({SYNC_B, SYNC_A});
                send_frame(pick_len(), 1'b1, -1, 2);
            end
            default:
            begin
                send_bad_length({SYNC_A, 8'($urandom_range(0, 255))});
                send_frame(pick_len(), 1'b1, -1, 1);
            end
        endcase
    endtask

    // Random mix: well-formed frames (mostly good CRC) dominate so payload and
    // record logic get exercised; broken sequences and raw noise fill the rest.
    task automatic run_mix(input int budget);
        int stop_at;
        int r;
        stop_at = sent_bytes + budget;
        while (sent_bytes < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                send_frame(pick_len(), $urandom_range(0, 9) != 0, -1, 0);
            else if (r < 94)
                send_broken($urandom_range(0, 3));
            else
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
        end
        settle();
    endtask

    initial
    begin : stimulus
        int k;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Directed, reset limits (1024, record 76).
        send_frame(0, 1'b1, -1, 0);         // empty frame, end marker
        send_frame(0, 1'b0, -1, 0);         // empty frame, bad CRC
        send_frame(1, 1'b1, -1, 0);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(SYNC_A);                  // 5A 5A A5: broken sync, second 5A restarts
        send_frame(2, 1'b0, -1, 0);
        push_byte(SYNC_A);                  // 5A then junk back to hunting
        push_byte(8'h00);
        send_bad_length(16'd1025);          // one over the cap
        send_bad_length(16'hFFFF);
        send_broken(2);
        send_broken(3);
        send_frame(80, 1'b1, 4, 0);         // tag where the record just fits
        send_frame(8, 1'b1, 2, 0);          // record larger than payload: no fit
        settle();
        run_mix(150);

        // Zero limit: only empty frames get through.
        set_limits(11'd0, 11'd1);
        run_mix(80);

        // Limit register above the cap; tag in the last byte still fits.
        set_limits(11'd2047, 11'd1);
        send_frame(100, 1'b1, 99, 0);
        send_bad_length(16'd1025);
        run_mix(80);

        // Record size zero: any tag fits.
        set_limits(11'd1024, 11'd0);
        run_mix(100);

        // Record size larger than any payload.
        set_limits(11'd16, 11'd2047);
        run_mix(80);

        for (k = 0; k < 3; k++)
        begin
            set_limits(11'($urandom_range(0, 1100)), 11'($urandom_range(1, 40)));
            run_mix(70);
        end

        settle();
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== crc_checked_frame_deframer_core.f =====
rtl/core/cfd_pkg.sv
rtl/core/cfd_parser.sv
rtl/core/cfd_out_reg.sv
rtl/core/crc_checked_frame_deframer_core.sv
sim/cfd_result_checker.sv
sim/tb_top.sv
